[sv/bdc_pkg.sv]
`default_nettype none
package bdc_pkg;

    localparam int POS_WIDTH   = 32;
    localparam int REST_WIDTH  = POS_WIDTH - 1;
    localparam int MASS_WIDTH  = 32;
    localparam int STIFF_WIDTH = 16;
    // stiffness is Q1.15, mass share is Q1.16
    localparam int STIFF_FRAC  = 15;
    localparam int SHARE_FRAC  = 16;
    localparam int SHARE_WIDTH = SHARE_FRAC + 1;
    localparam logic [SHARE_WIDTH-1:0] SHARE_HALF = SHARE_WIDTH'(1) << (SHARE_FRAC - 1);

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]   first_x;
        logic signed [POS_WIDTH-1:0]   first_y;
        logic signed [POS_WIDTH-1:0]   second_x;
        logic signed [POS_WIDTH-1:0]   second_y;
        logic        [MASS_WIDTH-1:0]  first_mass;
        logic        [MASS_WIDTH-1:0]  second_mass;
        logic                          first_fixed;
        logic                          second_fixed;
        logic        [REST_WIDTH-1:0]  rest_length;
        logic        [STIFF_WIDTH-1:0] bar_stiffness;
    } bdc_in_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] new_first_x;
        logic signed [POS_WIDTH-1:0] new_first_y;
        logic signed [POS_WIDTH-1:0] new_second_x;
        logic signed [POS_WIDTH-1:0] new_second_y;
        logic                        zero_length;
    } bdc_out_t;

endpackage
`default_nettype wire

[sv/bar_distance_constraint.sv]
`default_nettype none
// Bar distance constraint: one relaxation step of a two-endpoint bar.
// Input channel: drive request and pulse start; the item is taken at any
// clock edge where start is high and busy is low. busy stays low, so a new
// item may be offered in every cycle.
// Output channel: result is valid for exactly one cycle while done is high.
// The receiver cannot hold results off; results appear in input order.
// Throughput is one item per cycle. The latency is set by the bit-per-stage
// units: two squarers, the square root, the mass-share divider, the
// extension products, the stiffness products (16 stages) and the correction
// dividers.
// Reset clears every stage's valid bit at once; items in flight are dropped
// and no result follows them. There is no state between items.
module bar_distance_constraint (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bdc_pkg::bdc_in_t  request,
    output logic                   done,
    output bdc_pkg::bdc_out_t      result
);

    localparam int P    = bdc_pkg::POS_WIDTH;
    localparam int M    = P + 1;
    localparam int SW   = 2 * M;
    localparam int MW   = bdc_pkg::MASS_WIDTH;
    localparam int SUMW = MW + 1;
    localparam int SHW  = bdc_pkg::SHARE_WIDTH;
    localparam int STW  = bdc_pkg::STIFF_WIDTH;
    localparam int PW   = 2 * M;
    localparam int NNW  = PW + STW;
    localparam int CNW  = NNW + 1;
    localparam int CDW  = M + bdc_pkg::STIFF_FRAC;
    localparam int CQW  = M + 2;
    localparam int EW   = P + 4;
    localparam int LAT  = 1 + 1 + M + 1 + M + 1 + SHW + 1 + M + 1 + STW + 1 + CQW + 1;

    typedef struct packed {
        bdc_pkg::bdc_in_t item;
        logic             dx_neg;
        logic             dy_neg;
        logic [M-1:0]     dx_mag;
        logic [M-1:0]     dy_mag;
        logic             zero;
    } t1_t;

    typedef struct packed {
        t1_t          base;
        logic [M-1:0] span;
        logic         ext_neg;
        logic [M-1:0] ext_mag;
        logic         sum_zero;
    } t3_t;

    typedef struct packed {
        t3_t            base;
        logic [STW-1:0] mult1;
    } t4_t;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    logic             v0_reg;
    bdc_pkg::bdc_in_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= request;
        end
    end

    // differences and magnitudes
    logic signed [M-1:0] dx_next, dy_next;
    logic v1_reg;
    t1_t  t1_reg;
    t1_t  t1_next;

    always_comb
    begin
        dx_next = {in_reg.first_x[P-1], in_reg.first_x} - {in_reg.second_x[P-1], in_reg.second_x};
        dy_next = {in_reg.first_y[P-1], in_reg.first_y} - {in_reg.second_y[P-1], in_reg.second_y};
        t1_next.item   = in_reg;
        t1_next.dx_neg = dx_next[M-1];
        t1_next.dy_neg = dy_next[M-1];
        t1_next.dx_mag = dx_next[M-1] ? M'(-dx_next) : M'(dx_next);
        t1_next.dy_mag = dy_next[M-1] ? M'(-dy_next) : M'(dy_next);
        t1_next.zero   = (dx_next == '0) && (dy_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t1_next;
    end

    // squares
    logic [1:0][M-1:0]  sq_op;
    logic [1:0][PW-1:0] sq_prod;
    logic [$bits(t1_t)-1:0] sq_tag;
    logic sq_valid;

    assign sq_op[0] = t1_reg.dx_mag;
    assign sq_op[1] = t1_reg.dy_mag;

    bdc_mul #(.AW(M), .BW(M), .NL(2), .TW($bits(t1_t))) u_mul_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .a        (sq_op),
        .b        (sq_op),
        .in_tag   (t1_reg),
        .out_valid(sq_valid),
        .prod     (sq_prod),
        .out_tag  (sq_tag)
    );

    logic            v2_reg;
    logic [SW-1:0]   s_reg;
    t1_t             t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= sq_valid;
        end
    end

    // each magnitude is below 2^P, so the sum of squares fits 2*M bits
    always_ff @(posedge clk)
    begin
        s_reg  <= sq_prod[0] + sq_prod[1];
        t2_reg <= sq_tag;
    end

    // square root, two radicand bits per stage
    logic [M-1:0]   sq_valid_reg;
    logic [SW-1:0]  rad_reg  [M];
    logic [M+1:0]   rem_reg  [M];
    logic [M-1:0]   root_reg [M];
    t1_t            rt_reg   [M];

    for (genvar k = 0; k < M; k++) begin : g_sqrt
        logic          v_src;
        logic [SW-1:0] rad_src;
        logic [M+1:0]  rem_src;
        logic [M-1:0]  root_src;
        t1_t           t_src;
        logic [M+1:0]  rem_sh;
        logic [M+1:0]  trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_src    = v2_reg;
            assign rad_src  = s_reg;
            assign rem_src  = '0;
            assign root_src = '0;
            assign t_src    = t2_reg;
        end
        else begin : g_rest
            assign v_src    = sq_valid_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign t_src    = rt_reg[k-1];
        end

        assign rem_sh = {rem_src[M-1:0], rad_src[SW-1 -: 2]};
        assign trial  = {root_src, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_src << 2;
            rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg[k] <= {root_src[M-2:0], ge};
            rt_reg[k]   <= t_src;
        end
    end

    // extension and mass sum
    logic signed [M:0] ext_next;
    logic              v3_reg;
    t3_t               t3_reg;
    logic [SUMW-1:0]   sum_reg;

    assign ext_next = {1'b0, root_reg[M-1]} - (M + 1)'(rt_reg[M-1].item.rest_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= sq_valid_reg[M-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t3_reg.base     <= rt_reg[M-1];
        t3_reg.span     <= root_reg[M-1];
        t3_reg.ext_neg  <= ext_next[M];
        t3_reg.ext_mag  <= ext_next[M] ? M'(-ext_next) : M'(ext_next);
        sum_reg         <= SUMW'(rt_reg[M-1].item.first_mass)
                           + SUMW'(rt_reg[M-1].item.second_mass);
        t3_reg.sum_zero <= (rt_reg[M-1].item.first_mass == '0)
                           && (rt_reg[M-1].item.second_mass == '0);
    end

    // mass share of the first endpoint
    logic [0:0][MW+bdc_pkg::SHARE_FRAC-1:0] md_num;
    logic [0:0][SUMW-1:0]                   md_den;
    logic [0:0][SHW-1:0]                    md_quo;
    logic [$bits(t3_t)-1:0]                 md_tag;
    logic                                   md_valid;

    assign md_num[0] = {t3_reg.base.item.second_mass, {bdc_pkg::SHARE_FRAC{1'b0}}};
    assign md_den[0] = sum_reg;

    bdc_div #(.NW(MW + bdc_pkg::SHARE_FRAC), .DW(SUMW), .QW(SHW), .NL(1),
              .TW($bits(t3_t))) u_div_mass (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .num      (md_num),
        .den      (md_den),
        .in_tag   (t3_reg),
        .out_valid(md_valid),
        .quo      (md_quo),
        .out_tag  (md_tag)
    );

    t3_t                 md_t;
    logic [SHW-1:0]      share_eff;
    logic [SHW+STW-1:0]  share_prod;
    logic                v4_reg;
    t4_t                 t4_reg;

    assign md_t       = md_tag;
    assign share_eff  = md_t.sum_zero ? bdc_pkg::SHARE_HALF : md_quo[0];
    assign share_prod = (SHW + STW)'(share_eff) * (SHW + STW)'(md_t.base.item.bar_stiffness);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= md_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t4_reg.base  <= md_t;
        t4_reg.mult1 <= share_prod[bdc_pkg::SHARE_FRAC +: STW];
    end

    // extension times each axis component
    logic [1:0][M-1:0]  ep_a;
    logic [1:0][M-1:0]  ep_b;
    logic [1:0][PW-1:0] ep_prod;
    logic [$bits(t4_t)-1:0] ep_tag;
    logic ep_valid;

    assign ep_a[0] = t4_reg.base.ext_mag;
    assign ep_a[1] = t4_reg.base.ext_mag;
    assign ep_b[0] = t4_reg.base.base.dx_mag;
    assign ep_b[1] = t4_reg.base.base.dy_mag;

    bdc_mul #(.AW(M), .BW(M), .NL(2), .TW($bits(t4_t))) u_mul_ext (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4_reg),
        .a        (ep_a),
        .b        (ep_b),
        .in_tag   (t4_reg),
        .out_valid(ep_valid),
        .prod     (ep_prod),
        .out_tag  (ep_tag)
    );

    t4_t                ep_t;
    logic               v5_reg;
    t4_t                t5_reg;
    logic [STW-1:0]     mult2_reg;
    logic [1:0][PW-1:0] p_reg;

    assign ep_t = ep_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= ep_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t5_reg    <= ep_t;
        mult2_reg <= ep_t.base.base.item.bar_stiffness - ep_t.mult1;
        p_reg     <= ep_prod;
    end

    // stiffness share products: first x, first y, second x, second y
    logic [3:0][PW-1:0]  sp_a;
    logic [3:0][STW-1:0] sp_b;
    logic [3:0][NNW-1:0] sp_prod;
    logic [$bits(t4_t)-1:0] sp_tag;
    logic sp_valid;

    assign sp_a[0] = p_reg[0];
    assign sp_a[1] = p_reg[1];
    assign sp_a[2] = p_reg[0];
    assign sp_a[3] = p_reg[1];
    assign sp_b[0] = t5_reg.mult1;
    assign sp_b[1] = t5_reg.mult1;
    assign sp_b[2] = mult2_reg;
    assign sp_b[3] = mult2_reg;

    bdc_mul #(.AW(PW), .BW(STW), .NL(4), .TW($bits(t4_t))) u_mul_stiff (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v5_reg),
        .a        (sp_a),
        .b        (sp_b),
        .in_tag   (t5_reg),
        .out_valid(sp_valid),
        .prod     (sp_prod),
        .out_tag  (sp_tag)
    );

    // add half the divisor to round half away from zero
    t4_t                 sp_t;
    logic                v6_reg;
    t4_t                 t6_reg;
    logic [3:0][CNW-1:0] cn_reg;
    logic [3:0][CDW-1:0] cd_reg;

    assign sp_t = sp_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= sp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t6_reg <= sp_t;
        for (int l = 0; l < 4; l++)
        begin
            cn_reg[l] <= CNW'(sp_prod[l])
                         + CNW'({sp_t.base.span, {(bdc_pkg::STIFF_FRAC - 1){1'b0}}});
            cd_reg[l] <= {sp_t.base.span, {bdc_pkg::STIFF_FRAC{1'b0}}};
        end
    end

    logic [3:0][CQW-1:0]    cq;
    logic [$bits(t4_t)-1:0] cq_tag;
    logic                   cq_valid;

    bdc_div #(.NW(CNW), .DW(CDW), .QW(CQW), .NL(4), .TW($bits(t4_t))) u_div_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v6_reg),
        .num      (cn_reg),
        .den      (cd_reg),
        .in_tag   (t6_reg),
        .out_valid(cq_valid),
        .quo      (cq),
        .out_tag  (cq_tag)
    );

    // apply corrections and saturate
    function automatic logic signed [P-1:0] apply_corr(
        input logic signed [P-1:0] pos,
        input logic [CQW-1:0]      q,
        input logic                sub,
        input logic                hold
    );
        logic signed [EW-1:0] wide;
        logic signed [EW-1:0] pmax;
        logic signed [EW-1:0] pmin;
        pmax = EW'({1'b0, {(P - 1){1'b1}}});
        pmin = -pmax - EW'(1);
        wide = sub ? (EW'(pos) - $signed(EW'(q))) : (EW'(pos) + $signed(EW'(q)));
        if (hold)
        begin
            apply_corr = pos;
        end
        else if (wide > pmax)
        begin
            apply_corr = pmax[P-1:0];
        end
        else if (wide < pmin)
        begin
            apply_corr = pmin[P-1:0];
        end
        else
        begin
            apply_corr = wide[P-1:0];
        end
    endfunction

    t4_t               cq_t;
    logic              x_neg, y_neg;
    logic              hold1, hold2;
    logic              done_reg;
    bdc_pkg::bdc_out_t result_reg;

    assign cq_t  = cq_tag;
    assign x_neg = cq_t.base.ext_neg ^ cq_t.base.base.dx_neg;
    assign y_neg = cq_t.base.ext_neg ^ cq_t.base.base.dy_neg;
    assign hold1 = cq_t.base.base.zero || cq_t.base.base.item.first_fixed;
    assign hold2 = cq_t.base.base.zero || cq_t.base.base.item.second_fixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.new_first_x  <= apply_corr(cq_t.base.base.item.first_x, cq[0], !x_neg, hold1);
        result_reg.new_first_y  <= apply_corr(cq_t.base.base.item.first_y, cq[1], !y_neg, hold1);
        result_reg.new_second_x <= apply_corr(cq_t.base.base.item.second_x, cq[2], x_neg, hold2);
        result_reg.new_second_y <= apply_corr(cq_t.base.base.item.second_y, cq[3], y_neg, hold2);
        result_reg.zero_length  <= cq_t.base.base.zero;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted item did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching accepted item");

    a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.first_x == request.second_x)
               && (request.first_y == request.second_y)
        |-> ##LAT (done && result.zero_length
                   && (result.new_first_x == $past(request.first_x, LAT))
                   && (result.new_second_y == $past(request.second_y, LAT))))
        else $error("coincident endpoints were moved");

    a_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        accept && request.first_fixed
        |-> ##LAT ((result.new_first_x == $past(request.first_x, LAT))
                   && (result.new_first_y == $past(request.first_y, LAT))))
        else $error("pinned first endpoint moved");

endmodule
`default_nettype wire

[sv/bdc_mul.sv]
`default_nettype none
module bdc_mul #(
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int NL = 1,
    parameter int TW = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [NL-1:0][AW-1:0]       a,
    input  wire logic [NL-1:0][BW-1:0]       b,
    input  wire logic [TW-1:0]               in_tag,
    output logic                             out_valid,
    output logic      [NL-1:0][AW+BW-1:0]    prod,
    output logic      [TW-1:0]               out_tag
);

    localparam int PW = AW + BW;

    logic [BW-1:0]             valid_reg;
    logic [NL-1:0][AW-1:0]     a_reg   [BW];
    logic [NL-1:0][BW-1:0]     b_reg   [BW];
    logic [NL-1:0][PW-1:0]     acc_reg [BW];
    logic [TW-1:0]             tag_reg [BW];

    for (genvar k = 0; k < BW; k++) begin : g_stage
        logic                  v_src;
        logic [NL-1:0][AW-1:0] a_src;
        logic [NL-1:0][BW-1:0] b_src;
        logic [NL-1:0][PW-1:0] acc_src;
        logic [TW-1:0]         tag_src;
        logic [NL-1:0][PW-1:0] acc_next;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign a_src   = a;
            assign b_src   = b;
            assign acc_src = '0;
            assign tag_src = in_tag;
        end
        else begin : g_rest
            assign v_src   = valid_reg[k-1];
            assign a_src   = a_reg[k-1];
            assign b_src   = b_reg[k-1];
            assign acc_src = acc_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        // add one partial product per stage
        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                acc_next[l] = acc_src[l] +
                    (b_src[l][k] ? ({{BW{1'b0}}, a_src[l]} << k) : '0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            a_reg[k]   <= a_src;
            b_reg[k]   <= b_src;
            acc_reg[k] <= acc_next;
            tag_reg[k] <= tag_src;
        end
    end

    assign out_valid = valid_reg[BW-1];
    assign prod      = acc_reg[BW-1];
    assign out_tag   = tag_reg[BW-1];

endmodule
`default_nettype wire

[sv/bdc_div.sv]
`default_nettype none
module bdc_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int NL = 1,
    parameter int TW = 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [NL-1:0][NW-1:0]   num,
    input  wire logic [NL-1:0][DW-1:0]   den,
    input  wire logic [TW-1:0]           in_tag,
    output logic                         out_valid,
    output logic      [NL-1:0][QW-1:0]   quo,
    output logic      [TW-1:0]           out_tag
);

    // quotient must fit QW bits; one quotient bit per stage, top bit first
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW-1:0]             valid_reg;
    logic [NL-1:0][CW-1:0]     rem_reg [QW];
    logic [NL-1:0][DW-1:0]     den_reg [QW];
    logic [NL-1:0][QW-1:0]     quo_reg [QW];
    logic [TW-1:0]             tag_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic                  v_src;
        logic [NL-1:0][CW-1:0] rem_src;
        logic [NL-1:0][DW-1:0] den_src;
        logic [NL-1:0][QW-1:0] quo_src;
        logic [TW-1:0]         tag_src;
        logic [NL-1:0][CW-1:0] rem_next;
        logic [NL-1:0][QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            for (genvar l = 0; l < NL; l++) begin : g_ext
                assign rem_src[l] = CW'(num[l]);
            end
            assign den_src = den;
            assign quo_src = '0;
            assign tag_src = in_tag;
        end
        else begin : g_rest
            assign v_src   = valid_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        always_comb
        begin
            logic [CW-1:0] trial;
            logic          ge;
            for (int l = 0; l < NL; l++)
            begin
                trial       = CW'(den_src[l]) << SH;
                ge          = (rem_src[l] >= trial);
                rem_next[l] = ge ? (rem_src[l] - trial) : rem_src[l];
                quo_next[l] = quo_src[l] | (QW'(ge) << SH);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_src;
            quo_reg[k] <= quo_next;
            tag_reg[k] <= tag_src;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule
`default_nettype wire
